// ----- rtl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, command codes and the control store of the I2C master
// bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // command codes
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_STOP   = 3'd1;
  localparam logic [2:0] MODE_WRITE  = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_ACK    = 3'd4;
  localparam logic [2:0] MODE_NACK   = 3'd5;
  localparam logic [2:0] MODE_WAIT   = 3'd6;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // configuration register indexes
  localparam logic CFG_PHASE_TIME  = 1'b0;
  localparam logic CFG_SAMPLE_HOLD = 1'b1;

  localparam logic [7:0] PHASE_TIME_RESET  = 8'd3;
  localparam logic [7:0] SAMPLE_HOLD_RESET = 8'd1;

  localparam int unsigned PC_W  = 5;
  localparam int unsigned CNT_W = 3;
  localparam logic [CNT_W-1:0] LAST_BIT = 3'd7;

  // SCL source select
  localparam logic [1:0] SCL_KEEP = 2'd0;
  localparam logic [1:0] SCL_LO   = 2'd1;
  localparam logic [1:0] SCL_HI   = 2'd2;

  // SDA source select
  localparam logic [2:0] SDA_KEEP = 3'd0;
  localparam logic [2:0] SDA_LO   = 3'd1;
  localparam logic [2:0] SDA_HI   = 3'd2;
  localparam logic [2:0] SDA_BIT  = 3'd3;  // MSB of the write shifter
  localparam logic [2:0] SDA_LVL  = 3'd4;  // low for ack, high for nack

  // program entry points
  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_STOP  = 5'd3;
  localparam logic [PC_W-1:0] PC_WRITE = 5'd6;
  localparam logic [PC_W-1:0] PC_READ  = 5'd9;
  localparam logic [PC_W-1:0] PC_READ_LOOP = 5'd10;
  localparam logic [PC_W-1:0] PC_ACK   = 5'd13;
  localparam logic [PC_W-1:0] PC_WAIT  = 5'd17;
  localparam logic [PC_W-1:0] PC_NONE  = 5'd0;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_byte;
    logic [7:0] sda_samples;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] hold_us;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       last_phase;
  } out_word_t;

  typedef struct packed {
    logic [1:0]      scl_sel;
    logic [2:0]      sda_sel;
    logic            hold_sample;  // use the sample hold instead of phase time
    logic            loop_back;    // jump to target until eight bits are done
    logic            last;         // final step of the command
    logic [PC_W-1:0] target;
  } ucode_t;

  // line context handed to the phase datapath
  typedef struct packed {
    logic       scl_now;
    logic       sda_now;
    logic       wbit;
    logic [2:0] mode;
    logic [7:0] samples;
    logic [7:0] phase_time;
    logic [7:0] sample_hold;
    logic       at_end;
  } phase_ctx_t;

  function automatic ucode_t mk(input logic [1:0] scl, input logic [2:0] sda,
                                input logic hs, input logic lb, input logic lst,
                                input logic [PC_W-1:0] tgt);
    ucode_t u;
    u.scl_sel     = scl;
    u.sda_sel     = sda;
    u.hold_sample = hs;
    u.loop_back   = lb;
    u.last        = lst;
    u.target      = tgt;
    return u;
  endfunction

  // control store, one word per phase step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    case (pc)
      // start
      5'd0:  u = mk(SCL_HI,   SDA_HI,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd1:  u = mk(SCL_HI,   SDA_LO,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd2:  u = mk(SCL_LO,   SDA_LO,   1'b0, 1'b0, 1'b1, PC_NONE);
      // stop
      5'd3:  u = mk(SCL_KEEP, SDA_LO,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd4:  u = mk(SCL_HI,   SDA_LO,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd5:  u = mk(SCL_HI,   SDA_HI,   1'b0, 1'b0, 1'b1, PC_NONE);
      // write byte, one bit per pass
      5'd6:  u = mk(SCL_KEEP, SDA_BIT,  1'b0, 1'b0, 1'b0, PC_NONE);
      5'd7:  u = mk(SCL_HI,   SDA_BIT,  1'b0, 1'b0, 1'b0, PC_NONE);
      5'd8:  u = mk(SCL_LO,   SDA_BIT,  1'b0, 1'b1, 1'b1, PC_WRITE);
      // read byte
      5'd9:  u = mk(SCL_KEEP, SDA_HI,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd10: u = mk(SCL_HI,   SDA_HI,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd11: u = mk(SCL_HI,   SDA_HI,   1'b1, 1'b0, 1'b0, PC_NONE);
      5'd12: u = mk(SCL_LO,   SDA_HI,   1'b0, 1'b1, 1'b1, PC_READ_LOOP);
      // ack / nack
      5'd13: u = mk(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, 1'b0, PC_NONE);
      5'd14: u = mk(SCL_LO,   SDA_LVL,  1'b0, 1'b0, 1'b0, PC_NONE);
      5'd15: u = mk(SCL_HI,   SDA_LVL,  1'b0, 1'b0, 1'b0, PC_NONE);
      5'd16: u = mk(SCL_LO,   SDA_LVL,  1'b0, 1'b0, 1'b1, PC_NONE);
      // wait ack
      5'd17: u = mk(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, 1'b0, PC_NONE);
      5'd18: u = mk(SCL_LO,   SDA_HI,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd19: u = mk(SCL_HI,   SDA_HI,   1'b0, 1'b0, 1'b0, PC_NONE);
      5'd20: u = mk(SCL_LO,   SDA_HI,   1'b0, 1'b0, 1'b1, PC_NONE);
      default: u = mk(SCL_KEEP, SDA_KEEP, 1'b0, 1'b0, 1'b1, PC_NONE);
    endcase
    return u;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] mode);
    logic [PC_W-1:0] pc;
    case (mode)
      MODE_START: pc = PC_START;
      MODE_STOP:  pc = PC_STOP;
      MODE_WRITE: pc = PC_WRITE;
      MODE_READ:  pc = PC_READ;
      MODE_ACK:   pc = PC_ACK;
      MODE_NACK:  pc = PC_ACK;
      MODE_WAIT:  pc = PC_WAIT;
      default:    pc = PC_NONE;
    endcase
    return pc;
  endfunction

endpackage

// ----- rtl/i2cms_phase_gen.sv -----
// ----------------------------------------------------------------------------
// i2cms_phase_gen
// Datapath that turns one control word and the line context into one phase.
// ----------------------------------------------------------------------------
module i2cms_phase_gen (
  input  i2cms_pkg::ucode_t     ctrl,
  input  i2cms_pkg::phase_ctx_t ctx,
  output i2cms_pkg::out_word_t  phase
);

  logic scl;
  logic sda;

  always_comb begin
    case (ctrl.scl_sel)
      i2cms_pkg::SCL_LO: scl = 1'b0;
      i2cms_pkg::SCL_HI: scl = 1'b1;
      default:           scl = ctx.scl_now;
    endcase
  end

  always_comb begin
    case (ctrl.sda_sel)
      i2cms_pkg::SDA_LO:  sda = 1'b0;
      i2cms_pkg::SDA_HI:  sda = 1'b1;
      i2cms_pkg::SDA_BIT: sda = ctx.wbit;
      i2cms_pkg::SDA_LVL: sda = (ctx.mode == i2cms_pkg::MODE_NACK);
      default:            sda = ctx.sda_now;
    endcase
  end

  always_comb begin
    phase.scl_level  = scl;
    phase.sda_level  = sda;
    phase.hold_us    = ctrl.hold_sample ? ctx.sample_hold : ctx.phase_time;
    phase.read_data  = (ctx.at_end && ctx.mode == i2cms_pkg::MODE_READ) ?
                       ctx.samples : 8'd0;
    // ack when the slave held SDA low
    phase.ack_seen   = ctx.at_end && (ctx.mode == i2cms_pkg::MODE_WAIT) &&
                       !ctx.samples[0];
    phase.last_phase = ctx.at_end;
  end

endmodule

// ----- rtl/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Bit-level I2C master: one command word in, a run of timed SCL/SDA phase
// words out, driven by a small microprogram.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall  i2cms_pkg::in_word_t
//  out      out  out_valid/ out_stall out_word_t
//  cfg      in   cfg_we               cfg_addr (1b), cfg_wdata (8b)
//
// One phase word leaves per cycle while the output is not stalled: start and
// stop give 3 words, ack/nack/wait-ack 4, write 24, read 25, stepped by the
// microprogram step counter. The command is taken before its first phase
// word is made; the unused code is taken and gives no phase words.
// The next command is taken at the edge after the last phase enters the
// output register. Reset is synchronous; both lines come up high.
// An output stall freezes the step counter.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cms_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cms_pkg::out_word_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [7:0]           cfg_wdata
);

  logic                             busy;
  logic [i2cms_pkg::PC_W-1:0]       pc;
  logic [i2cms_pkg::CNT_W-1:0]      bit_cnt;
  logic [2:0]                       mode;
  logic [7:0]                       wshift;
  logic [7:0]                       samples;
  logic                             scl_now;
  logic                             sda_now;
  logic [7:0]                       phase_time;
  logic [7:0]                       sample_hold;

  i2cms_pkg::ucode_t     ctrl;
  i2cms_pkg::phase_ctx_t ctx;
  i2cms_pkg::out_word_t  phase;
  logic                  loop_taken;
  logic                  at_end;
  logic                  advance;
  logic                  in_take;

  assign ctrl       = i2cms_pkg::ucode_rom(pc);
  assign loop_taken = ctrl.loop_back && (bit_cnt != i2cms_pkg::LAST_BIT);
  assign at_end     = ctrl.last && !loop_taken;
  assign advance    = busy && (!out_valid || !out_stall);
  assign in_stall   = busy;
  assign in_take    = in_valid && !busy;

  always_comb begin
    ctx.scl_now     = scl_now;
    ctx.sda_now     = sda_now;
    ctx.wbit        = wshift[7];
    ctx.mode        = mode;
    ctx.samples     = samples;
    ctx.phase_time  = phase_time;
    ctx.sample_hold = sample_hold;
    ctx.at_end      = at_end;
  end

  i2cms_phase_gen u_phase_gen (
    .ctrl  (ctrl),
    .ctx   (ctx),
    .phase (phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      scl_now     <= 1'b1;
      sda_now     <= 1'b1;
      phase_time  <= i2cms_pkg::PHASE_TIME_RESET;
      sample_hold <= i2cms_pkg::SAMPLE_HOLD_RESET;
      pc          <= i2cms_pkg::PC_NONE;
      bit_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == i2cms_pkg::CFG_PHASE_TIME) begin
          phase_time <= cfg_wdata;
        end else begin
          sample_hold <= cfg_wdata;
        end
      end

      if (out_valid && !out_stall && !advance) begin
        out_valid <= 1'b0;
      end

      if (in_take) begin
        pc      <= i2cms_pkg::entry_pc(in_data.mode);
        bit_cnt <= '0;
        // unused command code drives nothing
        busy    <= (in_data.mode != i2cms_pkg::MODE_UNUSED);
      end

      if (advance) begin
        out_valid <= 1'b1;
        scl_now   <= phase.scl_level;
        sda_now   <= phase.sda_level;
        if (loop_taken) begin
          pc      <= ctrl.target;
          bit_cnt <= bit_cnt + 1'b1;
        end else if (at_end) begin
          busy <= 1'b0;
        end else begin
          pc <= pc + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode    <= in_data.mode;
      wshift  <= in_data.write_byte;
      samples <= in_data.sda_samples;
    end else if (advance && loop_taken) begin
      wshift <= {wshift[6:0], 1'b0};
    end
    if (advance) begin
      out_data <= phase;
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master bit sequencer. Master commands go in
// as words under random input gaps and output stalls. Every phase word that
// comes out is checked field by field against a line-level model of the
// sequencer kept in this file. A directed table runs first. Random
// transactions follow, under several timing register settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ITEMS_PER_SET  = 36;
  localparam int unsigned N_SETS         = 5;
  localparam int unsigned N_DIR          = 25;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    i2cms_pkg::in_word_t  cmd;
    logic                 pin;
    i2cms_pkg::out_word_t last_word;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  i2cms_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  i2cms_pkg::out_word_t out_data;
  logic                 cfg_we = 1'b0;
  logic                 cfg_addr = 1'b0;
  logic [7:0]           cfg_wdata = '0;

  // line model: current levels and timing registers
  logic                 line_scl, line_sda;
  logic [7:0]           phase_us, sample_us;
  i2cms_pkg::out_word_t phase_q[$];

  int unsigned mismatches = 0;
  int unsigned cmds_sent = 0;
  int unsigned calm_left = 0;
  dir_row_t    dir_tab [N_DIR];

  i2c_master_bit_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_phase(logic scl, logic sda, logic [7:0] hold);
    i2cms_pkg::out_word_t w;
    line_scl = scl;
    line_sda = sda;
    w = '0;
    w.scl_level = scl;
    w.sda_level = sda;
    w.hold_us = hold;
    phase_q.push_back(w);
  endfunction

  // append the phase words a command drives; the last one carries the status
  function automatic void predict_phases(i2cms_pkg::in_word_t cmd);
    int unsigned          n0;
    logic                 lvl;
    logic                 b;
    i2cms_pkg::out_word_t w;
    n0 = phase_q.size();
    case (cmd.mode)
      i2cms_pkg::MODE_START: begin
        add_phase(1'b1, 1'b1, phase_us);
        add_phase(1'b1, 1'b0, phase_us);
        add_phase(1'b0, 1'b0, phase_us);
      end
      i2cms_pkg::MODE_STOP: begin
        add_phase(line_scl, 1'b0, phase_us);
        add_phase(1'b1, 1'b0, phase_us);
        add_phase(1'b1, 1'b1, phase_us);
      end
      i2cms_pkg::MODE_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          b = cmd.write_byte[i];
          add_phase(line_scl, b, phase_us);
          add_phase(1'b1, b, phase_us);
          add_phase(1'b0, b, phase_us);
        end
      end
      i2cms_pkg::MODE_READ: begin
        add_phase(line_scl, 1'b1, phase_us);
        for (int i = 0; i < 8; i++) begin
          add_phase(1'b1, 1'b1, phase_us);
          add_phase(1'b1, 1'b1, sample_us);
          add_phase(1'b0, 1'b1, phase_us);
        end
      end
      i2cms_pkg::MODE_ACK, i2cms_pkg::MODE_NACK: begin
        lvl = (cmd.mode == i2cms_pkg::MODE_NACK);
        add_phase(1'b0, line_sda, phase_us);
        add_phase(1'b0, lvl, phase_us);
        add_phase(1'b1, lvl, phase_us);
        add_phase(1'b0, lvl, phase_us);
      end
      i2cms_pkg::MODE_WAIT: begin
        add_phase(1'b0, line_sda, phase_us);
        add_phase(1'b0, 1'b1, phase_us);
        add_phase(1'b1, 1'b1, phase_us);
        add_phase(1'b0, 1'b1, phase_us);
      end
      default: ;
    endcase
    if (phase_q.size() > n0) begin
      w = phase_q.pop_back();
      w.last_phase = 1'b1;
      if (cmd.mode == i2cms_pkg::MODE_READ) w.read_data = cmd.sda_samples;
      if (cmd.mode == i2cms_pkg::MODE_WAIT) w.ack_seen = ~cmd.sda_samples[0];
      phase_q.push_back(w);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic dir_row_t plain(logic [2:0] mode, logic [7:0] wb, logic [7:0] smp);
    dir_row_t r;
    r = '0;
    r.cmd.mode = mode;
    r.cmd.write_byte = wb;
    r.cmd.sda_samples = smp;
    return r;
  endfunction

  function automatic dir_row_t pinned(logic [2:0] mode, logic [7:0] wb, logic [7:0] smp,
                                      logic scl, logic sda, logic [7:0] rd, logic ack);
    dir_row_t r;
    r = plain(mode, wb, smp);
    r.pin = 1'b1;
    r.last_word = '{scl_level: scl, sda_level: sda,
                    hold_us: i2cms_pkg::PHASE_TIME_RESET,
                    read_data: rd, ack_seen: ack, last_phase: 1'b1};
    return r;
  endfunction

  // hand one command word over, with a random gap and now and then a full drain
  task automatic send_cmd(input i2cms_pkg::in_word_t cmd);
    int unsigned gap;
    bit          drain;
    gap = (calm_left > 0) ? 0 : pick_gap();
    drain = ($urandom_range(0, 49) == 0);
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 29) == 0) calm_left = 15;
    if (gap > 0 || drain) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (phase_q.size() != 0);
      end
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_phases(cmd);
    if (cmd.mode != i2cms_pkg::MODE_UNUSED) cmds_sent++;
  endtask

  task automatic send_op(input logic [2:0] mode, input logic [7:0] wb, input logic [7:0] smp);
    i2cms_pkg::in_word_t cmd;
    cmd.mode = mode;
    cmd.write_byte = wb;
    cmd.sda_samples = smp;
    send_cmd(cmd);
  endtask

  // drop valid, wait out every expected word, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (phase_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(input logic [7:0] pt, input logic [7:0] sh);
    cfg_we    <= 1'b1;
    cfg_addr  <= i2cms_pkg::CFG_PHASE_TIME;
    cfg_wdata <= pt;
    @(posedge clk);
    cfg_addr  <= i2cms_pkg::CFG_SAMPLE_HOLD;
    cfg_wdata <= sh;
    @(posedge clk);
    cfg_we    <= 1'b0;
    phase_us  = pt;
    sample_us = sh;
    @(posedge clk);
  endtask

  // one addressed transfer; a broken one ends without a stop
  task automatic send_transfer();
    logic [7:0]  addr;
    int unsigned nbytes;
    bit          broken;
    addr   = 8'($urandom_range(0, 255));
    nbytes = $urandom_range(1, 3);
    broken = ($urandom_range(0, 7) == 0);
    send_op(i2cms_pkg::MODE_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_op(i2cms_pkg::MODE_WRITE, addr, 8'($urandom_range(0, 255)));
    send_op(i2cms_pkg::MODE_WAIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    for (int k = 0; k < nbytes; k++) begin
      if (addr[0]) begin
        send_op(i2cms_pkg::MODE_READ, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
        send_op((k == nbytes - 1) ? i2cms_pkg::MODE_NACK : i2cms_pkg::MODE_ACK,
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_op(i2cms_pkg::MODE_WRITE, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
        send_op(i2cms_pkg::MODE_WAIT, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      end
    end
    if (!broken) begin
      send_op(i2cms_pkg::MODE_STOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  // output stalls; quiet windows give stretches with no stall
  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ((cyc % 1024) >= 256 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    i2cms_pkg::out_word_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (phase_q.size() == 0) begin
        $error("phase word %h with nothing expected", out_data);
        mismatches++;
      end else begin
        want = phase_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_data.scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(out_data.sda_level));
        check_field("hold_us", want.hold_us, out_data.hold_us);
        check_field("read_data", want.read_data, out_data.read_data);
        check_field("ack_seen", 8'(want.ack_seen), 8'(out_data.ack_seen));
        check_field("last_phase", 8'(want.last_phase), 8'(out_data.last_phase));
      end
    end
  end

  // watchdog: end the run when no word moves on either side for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] pt_tab [N_SETS];
    logic [7:0] sh_tab [N_SETS];
    int unsigned set_start;
    line_scl  = 1'b1;
    line_sda  = 1'b1;
    phase_us  = i2cms_pkg::PHASE_TIME_RESET;
    sample_us = i2cms_pkg::SAMPLE_HOLD_RESET;
    pt_tab = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    sh_tab = '{8'd0, 8'd255, 8'd77, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    dir_tab = '{
      pinned(i2cms_pkg::MODE_START, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
      pinned(i2cms_pkg::MODE_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0),
      pinned(i2cms_pkg::MODE_WAIT,  8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1),
      plain (i2cms_pkg::MODE_WRITE, 8'h00, 8'hFF),
      pinned(i2cms_pkg::MODE_WAIT,  8'hFF, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0),
      pinned(i2cms_pkg::MODE_READ,  8'h00, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0),
      pinned(i2cms_pkg::MODE_ACK,   8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0),
      pinned(i2cms_pkg::MODE_READ,  8'hFF, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0),
      pinned(i2cms_pkg::MODE_NACK,  8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0),
      pinned(i2cms_pkg::MODE_STOP,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0),
      plain (i2cms_pkg::MODE_STOP,  8'hFF, 8'hFF),
      plain (i2cms_pkg::MODE_UNUSED, 8'hFF, 8'hFF),
      plain (i2cms_pkg::MODE_START, 8'hFF, 8'hFF),
      plain (i2cms_pkg::MODE_WRITE, 8'hA5, 8'h5A),
      plain (i2cms_pkg::MODE_WAIT,  8'h00, 8'hFE),
      plain (i2cms_pkg::MODE_READ,  8'hFF, 8'h5A),
      plain (i2cms_pkg::MODE_ACK,   8'h00, 8'h00),
      plain (i2cms_pkg::MODE_READ,  8'h00, 8'hA5),
      plain (i2cms_pkg::MODE_NACK,  8'hFF, 8'hFF),
      plain (i2cms_pkg::MODE_START, 8'h00, 8'h00),
      plain (i2cms_pkg::MODE_WRITE, 8'h3C, 8'hC3),
      plain (i2cms_pkg::MODE_WAIT,  8'hFF, 8'h01),
      plain (i2cms_pkg::MODE_UNUSED, 8'h00, 8'h00),
      plain (i2cms_pkg::MODE_START, 8'h00, 8'h00),
      plain (i2cms_pkg::MODE_STOP,  8'h00, 8'h00)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table under reset timing
    for (int i = 0; i < N_DIR; i++) begin
      send_cmd(dir_tab[i].cmd);
      if (dir_tab[i].pin) begin
        void'(phase_q.pop_back());
        phase_q.push_back(dir_tab[i].last_word);
      end
    end

    // random transfers and noise under each timing setting
    for (int s = 0; s < N_SETS; s++) begin
      settle();
      set_timing(pt_tab[s], sh_tab[s]);
      set_start = cmds_sent;
      while (cmds_sent - set_start < ITEMS_PER_SET) begin
        if ($urandom_range(0, 9) < 2)
          send_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        else
          send_transfer();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
